### rtl/ire_pkg.sv
`default_nettype none

package ire_pkg;

    localparam int unsigned NUM_W = 12;
    localparam int unsigned SYM_W = 7;
    localparam int unsigned VAL_W = 10;

    localparam logic [NUM_W-1:0] NUM_MAX = 12'd3999;

    localparam logic [SYM_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYM_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYM_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYM_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYM_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYM_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYM_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYM_W-1:0] SYM_M    = 7'h4D;

    // One request as it sits in the queue.
    typedef struct packed {
        logic [NUM_W-1:0] number;
        logic             invalid;
    } t_item;

    // Queue handshake between front and back.
    typedef struct packed {
        logic  push;
        t_item item;
    } t_push;

    typedef struct packed {
        logic  empty;
        t_item item;
    } t_head;

    // One greedy step: its value and one or two letters.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [SYM_W-1:0] first;
        logic [SYM_W-1:0] second;
        logic             pair;
    } t_step;

    // Largest step that still fits into rem.
    function automatic t_step greedy_step(input logic [NUM_W-1:0] rem);
        t_step s;
        s = '{value: 10'd1, first: SYM_I, second: SYM_NONE, pair: 1'b0};
        priority if (rem >= 12'd1000) s = '{10'd1000, SYM_M, SYM_NONE, 1'b0};
        else if (rem >= 12'd900) s = '{10'd900, SYM_C, SYM_M, 1'b1};
        else if (rem >= 12'd500) s = '{10'd500, SYM_D, SYM_NONE, 1'b0};
        else if (rem >= 12'd400) s = '{10'd400, SYM_C, SYM_D, 1'b1};
        else if (rem >= 12'd100) s = '{10'd100, SYM_C, SYM_NONE, 1'b0};
        else if (rem >= 12'd90)  s = '{10'd90, SYM_X, SYM_C, 1'b1};
        else if (rem >= 12'd50)  s = '{10'd50, SYM_L, SYM_NONE, 1'b0};
        else if (rem >= 12'd40)  s = '{10'd40, SYM_X, SYM_L, 1'b1};
        else if (rem >= 12'd10)  s = '{10'd10, SYM_X, SYM_NONE, 1'b0};
        else if (rem >= 12'd9)   s = '{10'd9, SYM_I, SYM_X, 1'b1};
        else if (rem >= 12'd5)   s = '{10'd5, SYM_V, SYM_NONE, 1'b0};
        else if (rem >= 12'd4)   s = '{10'd4, SYM_I, SYM_V, 1'b1};
        else                     s = '{10'd1, SYM_I, SYM_NONE, 1'b0};
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/ire_front.sv
`default_nettype none

module ire_front (
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [ire_pkg::NUM_W-1:0]  i_number,
    input  wire logic                       i_full,
    output ire_pkg::t_push                  o_push
);

    // Hold the sender while the queue is full.
    assign o_in_stall = i_full;

    always_comb begin
        o_push.push          = i_in_valid && !i_full;
        o_push.item.number   = i_number;
        o_push.item.invalid  = (i_number == '0) || (i_number > ire_pkg::NUM_MAX);
    end

endmodule

`default_nettype wire

### rtl/ire_queue.sv
`default_nettype none

module ire_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ire_pkg::t_push i_push,
    output logic                o_full,
    input  wire logic           i_pop,
    output ire_pkg::t_head      o_head
);

    ire_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           n_wr_ptr;
    logic           n_rd_ptr;
    logic [1:0]     n_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.empty = (r_count == 2'd0);
    assign o_head.item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        unique case ({i_push.push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

`default_nettype wire

### rtl/ire_back.sv
`default_nettype none

module ire_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ire_pkg::t_head             i_head,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [ire_pkg::SYM_W-1:0]       o_symbol,
    output logic                            o_last,
    output logic                            o_invalid
);

    logic                       r_busy;
    logic                       r_inv;
    logic                       r_second;
    logic [ire_pkg::NUM_W-1:0]  r_rem;
    logic                       r_out_valid;
    logic [ire_pkg::SYM_W-1:0]  r_symbol;
    logic                       r_last;
    logic                       r_invalid;

    logic                       n_busy;
    logic                       n_second;
    logic [ire_pkg::NUM_W-1:0]  n_rem;
    logic [ire_pkg::SYM_W-1:0]  n_symbol;
    logic                       n_last;

    ire_pkg::t_step             step;
    logic [ire_pkg::NUM_W-1:0]  rem_sub;
    logic                       advance;

    assign step    = ire_pkg::greedy_step(r_rem);
    assign rem_sub = r_rem - {{(ire_pkg::NUM_W - ire_pkg::VAL_W){1'b0}}, step.value};
    assign advance = r_busy && (!r_out_valid || !i_out_stall);
    assign o_pop   = !r_busy && !i_head.empty;

    always_comb begin
        n_busy   = r_busy;
        n_second = r_second;
        n_rem    = r_rem;
        n_symbol = step.first;
        n_last   = 1'b0;
        if (r_inv) begin
            n_symbol = ire_pkg::SYM_NONE;
            n_last   = 1'b1;
            n_busy   = 1'b0;
        end else if (step.pair && !r_second) begin
            // first letter of a subtractive pair: hold rem
            n_second = 1'b1;
        end else begin
            n_symbol = r_second ? step.second : step.first;
            n_rem    = rem_sub;
            n_second = 1'b0;
            n_last   = (rem_sub == '0);
            n_busy   = (rem_sub != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (advance) begin
                r_busy <= n_busy;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem    <= i_head.item.number;
            r_inv    <= i_head.item.invalid;
            r_second <= 1'b0;
        end else if (advance) begin
            r_rem    <= n_rem;
            r_second <= n_second;
        end
        if (advance) begin
            r_symbol  <= n_symbol;
            r_last    <= n_last;
            r_invalid <= r_inv;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_invalid   = r_invalid;

endmodule

`default_nettype wire

### rtl/integer_to_roman_encoder_unit.sv
`default_nettype none

// channel   | valid        | stall        | payload
// ----------+--------------+--------------+---------------------------------
// input     | i_in_valid   | o_in_stall   | i_number (12 bits)
// output    | o_out_valid  | i_out_stall  | o_symbol (7), o_last, o_invalid
//
// One letter leaves per cycle from the back-end sequencer while i_out_stall is low;
// a request is popped and then emitted letter by letter (3888 gives the most letters).
// Out-of-range numbers give one result flagged invalid.
// A two-entry queue lets the front keep accepting while the back emits.
// Reset is synchronous, active low, and empties queue and output register.

module integer_to_roman_encoder_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [ire_pkg::NUM_W-1:0]  i_number,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [ire_pkg::SYM_W-1:0]       o_symbol,
    output logic                            o_last,
    output logic                            o_invalid
);

    ire_pkg::t_push push;
    ire_pkg::t_head head;
    logic           full;
    logic           pop;

    ire_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_number   (i_number),
        .i_full     (full),
        .o_push     (push)
    );

    ire_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    ire_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_symbol    (o_symbol),
        .o_last      (o_last),
        .o_invalid   (o_invalid)
    );

endmodule

`default_nettype wire
